// ===== hdl/bpqs_pkg.sv =====
// shared types, codes and constants for the bounded priority queue with rank select
`default_nettype none
package bpqs_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // fixed stream field widths
  localparam int ITEM_W     = 32;
  localparam int RANK_W     = 5;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_RANK   = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANK  = 2'd3
  } status_t;

  // one datapath action per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_FLAG,
    OP_INS_START,
    OP_INS_SHIFT,
    OP_INS_PUT,
    OP_REM_READ,
    OP_REM_CAPTURE,
    OP_REM_SHIFT,
    OP_REM_END,
    OP_RANK_READ,
    OP_RANK_CAPTURE,
    OP_TOP_READ,
    OP_TOP_CAPTURE,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic multi;
    logic desc;
    logic rank_ok;
    logic rdata_gt;
    logic idx_is_one;
    logic shift_more;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/bounded_priority_queue_select.sv =====
// top level of the bounded priority queue with k-th best select
//
//  channel   dir  handshake                tdata / tuser / data
//  s_axis    in   s_axis_tvalid/tready     request: item, rank / request kind
//  m_axis    out  m_axis_tvalid/tready     result: value, occupancy, top / status, top flag
//  cfg       in   cfg_valid/cfg_ready      order_descending bit
//
// one request at a time; the store is a ram kept in ascending order
// rank read: one ram read of the ranked slot; full, empty, bad rank, unused code: no ram access before the top read
// insert: every stored entry larger than the new value is moved up by the insertion shift
// remove in ascending order: the remaining entries shift down one per cycle,
// in descending order nothing shifts; the ram's single write port sets the shift rate
// reset clears occupancy and the order bit; a stalled result holds the engine in its last
// state, and the input is taken again only once the result register is loaded
`default_nettype none
module bounded_priority_queue_select #(
  parameter int CAPACITY   = bpqs_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = bpqs_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // request channel
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [bpqs_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // item_value, rank_index, zero pad
  input  wire logic [bpqs_pkg::IN_USER_W-1:0]   s_axis_tuser,  // req_type
  // result channel
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [bpqs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // result_value, occupancy, top_value, zero pad
  output logic      [bpqs_pkg::OUT_USER_W-1:0]  m_axis_tuser,  // status, top_valid
  // configuration write
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic                             cfg_data       // order_descending
);

  bpqs_pkg::cmd_t  cmd;
  bpqs_pkg::stat_t stat;

  // register write always taken; the user must write only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  // sequencer issues one datapath command per cycle
  bpqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, count, order bit and result register
  bpqs_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule
`default_nettype wire

// ===== hdl/bpqs_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module bpqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bpqs_ctrl.sv =====
// sequencer that steps the datapath through insert, remove and rank requests
`default_nettype none
module bpqs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bpqs_pkg::stat_t stat,
  output bpqs_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_CAP,
    S_REM_SH,
    S_REM_END,
    S_RNK_CAP,
    S_FIN,
    S_TOP,
    S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = bpqs_pkg::OP_NONE;
    cmd.code   = bpqs_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = bpqs_pkg::OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.req)
          bpqs_pkg::REQ_INSERT: begin
            if (stat.full) begin
              cmd.op     = bpqs_pkg::OP_FLAG;
              cmd.code   = bpqs_pkg::ST_FULL;
              state_next = S_FIN;
            end else begin
              cmd.op     = bpqs_pkg::OP_INS_START;
              state_next = stat.empty ? S_INS_PUT : S_INS_CMP;
            end
          end
          bpqs_pkg::REQ_REMOVE: begin
            if (stat.empty) begin
              cmd.op     = bpqs_pkg::OP_FLAG;
              cmd.code   = bpqs_pkg::ST_EMPTY;
              state_next = S_FIN;
            end else begin
              cmd.op     = bpqs_pkg::OP_REM_READ;
              state_next = S_REM_CAP;
            end
          end
          bpqs_pkg::REQ_RANK: begin
            if (!stat.rank_ok) begin
              cmd.op     = bpqs_pkg::OP_FLAG;
              cmd.code   = bpqs_pkg::ST_RANK;
              state_next = S_FIN;
            end else begin
              cmd.op     = bpqs_pkg::OP_RANK_READ;
              state_next = S_RNK_CAP;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_INS_CMP: begin
        if (stat.rdata_gt) begin
          cmd.op     = bpqs_pkg::OP_INS_SHIFT;
          state_next = stat.idx_is_one ? S_INS_PUT : S_INS_CMP;
        end else begin
          cmd.op     = bpqs_pkg::OP_INS_PUT;
          state_next = S_FIN;
        end
      end
      S_INS_PUT: begin
        cmd.op     = bpqs_pkg::OP_INS_PUT;
        state_next = S_FIN;
      end
      S_REM_CAP: begin
        cmd.op     = bpqs_pkg::OP_REM_CAPTURE;
        state_next = (!stat.desc && stat.multi) ? S_REM_SH : S_REM_END;
      end
      S_REM_SH: begin
        cmd.op     = bpqs_pkg::OP_REM_SHIFT;
        state_next = stat.shift_more ? S_REM_SH : S_REM_END;
      end
      S_REM_END: begin
        cmd.op     = bpqs_pkg::OP_REM_END;
        state_next = S_FIN;
      end
      S_RNK_CAP: begin
        cmd.op     = bpqs_pkg::OP_RANK_CAPTURE;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op     = bpqs_pkg::OP_TOP_READ;
        state_next = S_TOP;
      end
      S_TOP: begin
        cmd.op     = bpqs_pkg::OP_TOP_CAPTURE;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = bpqs_pkg::OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bpqs_dp.sv =====
// datapath: sorted value store, count, request registers and output register
`default_nettype none
module bpqs_dp #(
  parameter int CAPACITY   = bpqs_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = bpqs_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_data,
  input  wire logic [bpqs_pkg::IN_DATA_W-1:0]    in_data,
  input  wire logic [bpqs_pkg::IN_USER_W-1:0]    in_user,
  input  wire bpqs_pkg::cmd_t                    cmd,
  output bpqs_pkg::stat_t                        stat,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [bpqs_pkg::OUT_DATA_W-1:0]   out_data,
  output logic      [bpqs_pkg::OUT_USER_W-1:0]   out_user
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (CW > bpqs_pkg::RANK_W) ? CW : bpqs_pkg::RANK_W;

  logic                                order_desc;
  logic [CW-1:0]                       count;
  logic [IW-1:0]                       idx;
  bpqs_pkg::req_t                      req_r;
  logic signed [VALUE_BITS-1:0]        val_r;
  logic [bpqs_pkg::RANK_W-1:0]         rank_r;
  logic signed [VALUE_BITS-1:0]        result_r;
  bpqs_pkg::status_t                   code_r;
  logic signed [VALUE_BITS-1:0]        top_r;

  logic                                ram_we;
  logic [IW-1:0]                       ram_waddr;
  logic [VALUE_BITS-1:0]               ram_wdata;
  logic                                ram_re;
  logic [IW-1:0]                       ram_raddr;
  logic [VALUE_BITS-1:0]               ram_rdata;
  logic signed [VALUE_BITS-1:0]        rd;

  logic signed [bpqs_pkg::ITEM_W-1:0]  in_item;
  logic [CW-1:0]                       count_m1;
  logic [IW-1:0]                       top_addr;
  logic [KW-1:0]                       rank_k;
  logic [KW-1:0]                       count_k;
  logic [KW-1:0]                       rank_pos;
  logic                                top_ok;
  logic signed [bpqs_pkg::ITEM_W-1:0]  top_out;

  assign rd       = ram_rdata;
  assign in_item  = in_data[bpqs_pkg::ITEM_W-1:0];
  assign count_m1 = count - CW'(1);
  assign top_addr = order_desc ? count_m1[IW-1:0] : IW'(0);
  assign rank_k   = KW'(rank_r);
  assign count_k  = KW'(count);
  assign rank_pos = order_desc ? (count_k - rank_k) : (rank_k - KW'(1));
  assign top_ok   = (count != CW'(0));
  assign top_out  = top_ok ? bpqs_pkg::ITEM_W'(top_r) : '0;

  assign stat.req        = req_r;
  assign stat.full       = (count >= CW'(CAPACITY));
  assign stat.empty      = (count == CW'(0));
  assign stat.multi      = (count > CW'(1));
  assign stat.desc       = order_desc;
  assign stat.rank_ok    = (rank_k != KW'(0)) && (rank_k <= count_k);
  assign stat.rdata_gt   = (rd > val_r);
  assign stat.idx_is_one = (idx == IW'(1));
  assign stat.shift_more = ((CW + 1)'(idx) + (CW + 1)'(2)) < (CW + 1)'(count);
  assign stat.out_free   = !out_valid || out_ready;

  // ram port steering per command
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = rd;
    ram_re    = 1'b0;
    ram_raddr = top_addr;
    unique case (cmd.op)
      bpqs_pkg::OP_INS_START: begin
        ram_re    = 1'b1;
        ram_raddr = count_m1[IW-1:0];
      end
      bpqs_pkg::OP_INS_SHIFT: begin
        ram_we    = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = idx - IW'(2);
      end
      bpqs_pkg::OP_INS_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = val_r;
      end
      bpqs_pkg::OP_REM_READ, bpqs_pkg::OP_TOP_READ: begin
        ram_re = 1'b1;
      end
      bpqs_pkg::OP_REM_CAPTURE: begin
        ram_re    = 1'b1;
        ram_raddr = IW'(1);
      end
      bpqs_pkg::OP_REM_SHIFT: begin
        ram_we    = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = idx + IW'(2);
      end
      bpqs_pkg::OP_RANK_READ: begin
        ram_re    = 1'b1;
        ram_raddr = rank_pos[IW-1:0];
      end
      bpqs_pkg::OP_NONE, bpqs_pkg::OP_LATCH, bpqs_pkg::OP_FLAG, bpqs_pkg::OP_REM_END,
      bpqs_pkg::OP_RANK_CAPTURE, bpqs_pkg::OP_TOP_CAPTURE, bpqs_pkg::OP_OUT_LOAD: begin
      end
      default: begin
      end
    endcase
  end

  bpqs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      order_desc <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        order_desc <= cfg_data;
      end
      if (cmd.op == bpqs_pkg::OP_INS_PUT) begin
        count <= count + CW'(1);
      end else if (cmd.op == bpqs_pkg::OP_REM_END) begin
        count <= count_m1;
      end
      if (cmd.op == bpqs_pkg::OP_OUT_LOAD) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bpqs_pkg::OP_LATCH: begin
        req_r    <= bpqs_pkg::req_t'(in_user[bpqs_pkg::REQ_W-1:0]);
        val_r    <= VALUE_BITS'(in_item);
        rank_r   <= in_data[bpqs_pkg::ITEM_W +: bpqs_pkg::RANK_W];
        result_r <= '0;
        code_r   <= bpqs_pkg::ST_OK;
      end
      bpqs_pkg::OP_FLAG: begin
        code_r <= cmd.code;
      end
      bpqs_pkg::OP_INS_START: begin
        idx <= count[IW-1:0];
      end
      bpqs_pkg::OP_INS_SHIFT: begin
        idx <= idx - IW'(1);
      end
      bpqs_pkg::OP_REM_CAPTURE: begin
        result_r <= rd;
        idx      <= '0;
      end
      bpqs_pkg::OP_REM_SHIFT: begin
        idx <= idx + IW'(1);
      end
      bpqs_pkg::OP_RANK_CAPTURE: begin
        result_r <= rd;
      end
      bpqs_pkg::OP_TOP_CAPTURE: begin
        top_r <= rd;
      end
      bpqs_pkg::OP_OUT_LOAD: begin
        // zero pad above the three packed fields
        out_data <= bpqs_pkg::OUT_DATA_W'({top_out, bpqs_pkg::OCC_W'(count),
                                           bpqs_pkg::ITEM_W'(result_r)});
        out_user <= {top_ok, code_r};
      end
      bpqs_pkg::OP_NONE, bpqs_pkg::OP_INS_PUT, bpqs_pkg::OP_REM_READ,
      bpqs_pkg::OP_REM_END, bpqs_pkg::OP_RANK_READ, bpqs_pkg::OP_TOP_READ: begin
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking stream testbench for the bounded priority queue with k-th best select
`default_nettype none
module testbench;

  localparam int          CAP         = 16;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          TAIL_CYCLES = 40;
  localparam int          PHASE_ITEMS = 150;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;     // request code with no operation
  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  typedef struct {
    bpqs_pkg::status_t status;
    logic [31:0]       value;
    logic [4:0]        occupancy;
    logic [31:0]       top;
    logic              top_ok;
  } queue_result_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [bpqs_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;  // item_value, rank_index, zero pad
  logic [bpqs_pkg::IN_USER_W-1:0]   s_axis_tuser = '0;  // req_type
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [bpqs_pkg::OUT_DATA_W-1:0]  m_axis_tdata;  // result_value, occupancy, top_value, zero pad
  logic [bpqs_pkg::OUT_USER_W-1:0]  m_axis_tuser;  // status, top_valid
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic                             cfg_data = 1'b0;

  // shadow copy of the store: ascending values and how many are held
  logic signed [31:0] held_vals [CAP];
  int                 held_count = 0;
  logic               order_desc = 1'b0;

  queue_result_t      pending_results [$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 status_seen [4] = '{0, 0, 0, 0};
  int                 request_count = 0;
  int                 order_writes = 0;
  bit                 tx_idle_on = 1'b1;
  bit                 rx_stall_on = 1'b1;
  int                 rx_hold = 0;

  bounded_priority_queue_select i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // index into the ascending store of the k-th best value
  function automatic int best_slot(int k);
    return order_desc ? (held_count - k) : (k - 1);
  endfunction

  // predicted effect of one request on the shadow store
  function automatic queue_result_t apply_request(logic [1:0] kind, logic signed [31:0] val,
                                                  logic [4:0] rank);
    queue_result_t res;
    int            i;
    int            at;
    res.status = bpqs_pkg::ST_OK;
    res.value  = '0;
    if (kind == bpqs_pkg::REQ_INSERT) begin
      if (held_count >= CAP) begin
        res.status = bpqs_pkg::ST_FULL;
      end else begin
        // insertion sort step: move larger values up one slot
        i = held_count;
        while (i > 0 && held_vals[i-1] > val) begin
          held_vals[i] = held_vals[i-1];
          i--;
        end
        held_vals[i] = val;
        held_count++;
      end
    end else if (kind == bpqs_pkg::REQ_REMOVE) begin
      if (held_count == 0) begin
        res.status = bpqs_pkg::ST_EMPTY;
      end else begin
        at = best_slot(1);
        res.value = held_vals[at];
        for (i = at; i + 1 < held_count; i++) held_vals[i] = held_vals[i+1];
        held_count--;
      end
    end else if (kind == bpqs_pkg::REQ_RANK) begin
      if (rank == 0 || rank > held_count) res.status = bpqs_pkg::ST_RANK;
      else res.value = held_vals[best_slot(rank)];
    end
    // unused code leaves everything alone and reports ok
    res.occupancy = held_count[4:0];
    res.top_ok    = (held_count > 0);
    res.top       = (held_count > 0) ? held_vals[best_slot(1)] : '0;
    return res;
  endfunction

  // one request transaction; valid stays up when no gap follows
  task automatic send_request(logic [1:0] kind, logic signed [31:0] val, logic [4:0] rank);
    int gap;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, rank, val};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(apply_request(kind, val, rank));
    status_seen[pending_results[$].status]++;
    request_count++;
  endtask

  // hold the sender until every predicted result has come back
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // order changes only with the block idle
  task automatic write_order(logic desc);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_data  <= desc;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    order_desc = desc;
    order_writes++;
  endtask

  // result checker: compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser[1:0] !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, m_axis_tuser[1:0]);
          error_count++;
        end
        if (m_axis_tdata[31:0] !== want.value) begin
          $error("result_value: expected %0d actual %0d",
                 $signed(want.value), $signed(m_axis_tdata[31:0]));
          error_count++;
        end
        if (m_axis_tdata[36:32] !== want.occupancy) begin
          $error("occupancy: expected %0d actual %0d", want.occupancy, m_axis_tdata[36:32]);
          error_count++;
        end
        if (m_axis_tdata[68:37] !== want.top) begin
          $error("top_value: expected %0d actual %0d",
                 $signed(want.top), $signed(m_axis_tdata[68:37]));
          error_count++;
        end
        if (m_axis_tuser[2] !== want.top_ok) begin
          $error("top_valid: expected %0d actual %0d", want.top_ok, m_axis_tuser[2]);
          error_count++;
        end
      end
    end
  end

  // receiver pacing: ready bursts broken by random stalls
  always @(posedge clk) begin : rx_pacing
    int stall;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      stall = pick_gap(rx_stall_on);
      if (stall == 0) begin
        m_axis_tready <= 1'b1;
        rx_hold       <= $urandom_range(0, 4);
      end else begin
        m_axis_tready <= 1'b0;
        rx_hold       <= stall - 1;
      end
    end
  end

  // empty-store errors and the unused request code
  task automatic test_empty_and_unused();
    write_order(1'b0);
    send_request(bpqs_pkg::REQ_REMOVE, 32'sd0, 5'd0);
    send_request(bpqs_pkg::REQ_RANK, 32'sd0, 5'd1);
    send_request(bpqs_pkg::REQ_RANK, 32'sd0, 5'd0);
    send_request(REQ_UNUSED, VAL_MAX, 5'd16);
  endtask

  // value extremes, duplicates and rank bounds in ascending order
  task automatic test_extremes_and_duplicates();
    send_request(bpqs_pkg::REQ_INSERT, VAL_MAX, 5'd0);
    send_request(bpqs_pkg::REQ_INSERT, VAL_MIN, 5'd0);
    send_request(bpqs_pkg::REQ_INSERT, 32'sd0, 5'd0);
    send_request(bpqs_pkg::REQ_INSERT, -32'sd1, 5'd0);
    send_request(bpqs_pkg::REQ_INSERT, -32'sd1, 5'd0);
    send_request(bpqs_pkg::REQ_RANK, 32'sd0, 5'd0);
    send_request(bpqs_pkg::REQ_RANK, 32'sd0, 5'd5);
    send_request(bpqs_pkg::REQ_RANK, 32'sd0, 5'd6);
    send_request(bpqs_pkg::REQ_RANK, 32'sd0, 5'd3);
    send_request(bpqs_pkg::REQ_REMOVE, 32'sd0, 5'd0);
  endtask

  // flipping the order reads the same store from the other end
  task automatic test_order_flip();
    write_order(1'b1);
    send_request(bpqs_pkg::REQ_RANK, 32'sd0, 5'd1);
    send_request(bpqs_pkg::REQ_REMOVE, 32'sd0, 5'd0);
    send_request(bpqs_pkg::REQ_RANK, 32'sd0, 5'd3);
    send_request(REQ_UNUSED, 32'sd0, 5'd0);
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    // a narrow band makes duplicates common
    if (r < 5) return int'($urandom_range(0, 15)) - 8;
    return $urandom;
  endfunction

  function automatic logic [4:0] pick_rank();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 5'd0;
    if (r == 1 || held_count == 0) return 5'($urandom_range(0, CAP));
    return 5'($urandom_range(1, held_count));
  endfunction

  // one random phase: order, insert share and idling fixed for the phase
  task automatic test_random_phase(logic desc, int insert_pct, bit idle_on);
    int          r;
    logic [1:0]  kind;
    write_order(desc);
    tx_idle_on  = idle_on;
    rx_stall_on = idle_on;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == PHASE_ITEMS / 2) wait_all_results();
      r = $urandom_range(0, 99);
      if (r < insert_pct) kind = bpqs_pkg::REQ_INSERT;
      else if (r < insert_pct + (100 - insert_pct) / 2) kind = bpqs_pkg::REQ_REMOVE;
      else if (r < 98) kind = bpqs_pkg::REQ_RANK;
      else kind = REQ_UNUSED;
      send_request(kind, pick_value(), pick_rank());
    end
  endtask

  task automatic test_random_traffic();
    test_random_phase(1'b0, 50, 1'b1);
    test_random_phase(1'b1, 70, 1'b1);   // runs into full
    test_random_phase(1'b0, 30, 1'b1);   // runs into empty
    test_random_phase(1'b1, 50, 1'b0);
    test_random_phase(1'b0, 80, 1'b1);
    test_random_phase(1'b1, 25, 1'b1);
    test_random_phase(1'b0, 60, 1'b0);
    test_random_phase(1'b1, 55, 1'b1);
    test_random_phase(1'b0, 75, 1'b1);
    test_random_phase(1'b1, 40, 1'b1);
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_unused();
    test_extremes_and_duplicates();
    test_order_flip();
    test_random_traffic();
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      error_count++;
    end
    $display("%0d requests in %0d order settings: %0d ok, %0d empty, %0d full, %0d bad rank",
             request_count, order_writes, status_seen[bpqs_pkg::ST_OK],
             status_seen[bpqs_pkg::ST_EMPTY], status_seen[bpqs_pkg::ST_FULL],
             status_seen[bpqs_pkg::ST_RANK]);
    $display("%0d mismatches found", error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
